[rtl/core/zkid_pkg.sv]
// Shared types and codes for the identification verifier.
// Used by zkid_ctrl, zkid_dp and zero_knowledge_id_verifier; depends on nothing.
package zkid_pkg;

   localparam int ROUND_WIDTH = 8;

   // request operation codes
   localparam logic [1:0] OP_START    = 2'd0;
   localparam logic [1:0] OP_COMMIT   = 2'd1;
   localparam logic [1:0] OP_RESPONSE = 2'd2;
   localparam logic [1:0] OP_RESERVED = 2'd3;

   // configuration register indexes
   localparam logic [1:0] CSR_MODULUS      = 2'd0;
   localparam logic [1:0] CSR_PUBLIC_VALUE = 2'd1;
   localparam logic [1:0] CSR_ROUND_COUNT  = 2'd2;

   typedef enum logic {
      ASEL_ONE,
      ASEL_ACC
   } a_sel_type;

   typedef enum logic [1:0] {
      BSEL_Y,
      BSEL_X,
      BSEL_V
   } b_sel_type;

   typedef struct packed {
      logic      capture_commit;
      logic      capture_resp;
      logic      start;
      logic      save_lhs;
      a_sel_type a_sel;
      b_sel_type b_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic equal;
      logic challenge;
   } dp_status_type;

endpackage

[rtl/core/zero_knowledge_id_verifier.sv]
// Top level of the identification verifier: configuration registers, controller and datapath.
// Depends on zkid_pkg, zkid_ctrl and zkid_dp.
//
// Usage: program modulus n, public value v and round count through the csr_ channel
// (index 0, 1, 2; csr_ready is always high; write only while no request is in flight).
// Requests arrive on req_ (valid/stall): a start opens a session, a commitment x is
// answered with its random_bit as the challenge, and a response y is checked as
// y^2 mod n == x * v^e mod n. Every request gives exactly one rsp_ result.
// Timing: start, commitment and reserved requests, and a response outside its phase, give
// their result in the cycle after acceptance. A response in its phase runs three (e = 0)
// or four (e = 1) passes of the shared shift-and-add modular multiplier, each a load, one
// double and one add per bit of the multiplier, and a hand-back to the controller; the
// multiplier sets the rate, one request is worked on at a time.
// A request is taken while the previous result still sits in the output register as long
// as that result is taken in the same cycle; a stalled result holds and stalls req_.
// Reset: registers return to n = 2, v = 0, 20 rounds; no session is open.
module zero_knowledge_id_verifier
   import zkid_pkg::*;
#(
   parameter int VALUE_WIDTH = 40
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_operation,
   input  logic [VALUE_WIDTH-1:0] req_value,
   input  logic                   req_random_bit,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_challenge,
   output logic                   rsp_challenge_valid,
   output logic                   rsp_round_checked,
   output logic                   rsp_round_ok,
   output logic                   rsp_session_passed,
   output logic                   rsp_session_failed,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [VALUE_WIDTH-1:0] csr_data
);

   logic [VALUE_WIDTH-1:0] modulus_ff, modulus_in;
   logic [VALUE_WIDTH-1:0] public_ff, public_in;
   logic [ROUND_WIDTH-1:0] rounds_cfg_ff, rounds_cfg_in;
   dp_cmd_type             cmd;
   dp_status_type          status;

   // configuration writes are always taken
   assign csr_ready = 1'b1;

   always_comb begin
      modulus_in    = modulus_ff;
      public_in     = public_ff;
      rounds_cfg_in = rounds_cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MODULUS:      modulus_in    = csr_data;
            CSR_PUBLIC_VALUE: public_in     = csr_data;
            CSR_ROUND_COUNT:  rounds_cfg_in = csr_data[ROUND_WIDTH-1:0];
            default: begin
               // drop writes to unused indexes
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff    <= VALUE_WIDTH'(2);
         public_ff     <= '0;
         rounds_cfg_ff <= ROUND_WIDTH'(20);
      end else begin
         modulus_ff    <= modulus_in;
         public_ff     <= public_in;
         rounds_cfg_ff <= rounds_cfg_in;
      end
   end

   // session sequencing and the result register
   zkid_ctrl u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_operation       (req_operation),
      .req_random_bit      (req_random_bit),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_challenge       (rsp_challenge),
      .rsp_challenge_valid (rsp_challenge_valid),
      .rsp_round_checked   (rsp_round_checked),
      .rsp_round_ok        (rsp_round_ok),
      .rsp_session_passed  (rsp_session_passed),
      .rsp_session_failed  (rsp_session_failed),
      .round_count         (rounds_cfg_ff),
      .cmd                 (cmd),
      .status              (status)
   );

   // stored operands and the modular multiplier
   zkid_dp #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_value      (req_value),
      .req_random_bit (req_random_bit),
      .modulus        (modulus_ff),
      .public_value   (public_ff)
   );

endmodule

[rtl/core/zkid_dp.sv]
// Datapath: stored commitment, challenge and response, and a shift-and-add modular multiplier.
// Depends on zkid_pkg; driven by zkid_ctrl through dp_cmd_type.
module zkid_dp
   import zkid_pkg::*;
#(
   parameter int VALUE_WIDTH = 40
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dp_cmd_type             cmd,
   output dp_status_type          status,
   input  logic [VALUE_WIDTH-1:0] req_value,
   input  logic                   req_random_bit,
   input  logic [VALUE_WIDTH-1:0] modulus,
   input  logic [VALUE_WIDTH-1:0] public_value
);

   localparam int CW = $clog2(VALUE_WIDTH + 1);

   logic [VALUE_WIDTH-1:0] n;
   logic [VALUE_WIDTH-1:0] x_ff, y_ff, lhs_ff, acc_ff, a_ff, b_ff;
   logic [VALUE_WIDTH-1:0] x_in, y_in, lhs_in, acc_in, a_in, b_in;
   logic                   e_ff, e_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic                   half_ff, half_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;

   logic [VALUE_WIDTH:0]   dbl, dbl_sub, sum, sum_sub;
   logic [VALUE_WIDTH-1:0] addend, b_pick;

   // treat a modulus below two as two
   assign n = (modulus < VALUE_WIDTH'(2)) ? VALUE_WIDTH'(2) : modulus;

   assign dbl     = {acc_ff, 1'b0};
   assign dbl_sub = dbl - {1'b0, n};
   assign addend  = b_ff[VALUE_WIDTH-1] ? a_ff : '0;
   assign sum     = {1'b0, acc_ff} + {1'b0, addend};
   assign sum_sub = sum - {1'b0, n};

   always_comb begin
      unique case (cmd.b_sel)
         BSEL_Y:  b_pick = y_ff;
         BSEL_X:  b_pick = x_ff;
         BSEL_V:  b_pick = public_value;
         default: b_pick = '0;
      endcase
   end

   always_comb begin
      x_in    = x_ff;
      e_in    = e_ff;
      y_in    = y_ff;
      lhs_in  = lhs_ff;
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;
      half_in = half_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (cmd.capture_commit) begin
         x_in = req_value;
         e_in = req_random_bit;
      end
      if (cmd.capture_resp) begin
         y_in = req_value;
      end
      if (cmd.start) begin
         // open a pass: acc = a * b mod n, b taken MSB first
         if (cmd.save_lhs) begin
            lhs_in = acc_ff;
         end
         a_in    = (cmd.a_sel == ASEL_ONE) ? VALUE_WIDTH'(1) : acc_ff;
         b_in    = b_pick;
         acc_in  = '0;
         cnt_in  = CW'(VALUE_WIDTH);
         half_in = 1'b0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!half_ff) begin
            // double acc mod n
            acc_in  = dbl_sub[VALUE_WIDTH] ? dbl[VALUE_WIDTH-1:0] : dbl_sub[VALUE_WIDTH-1:0];
            half_in = 1'b1;
         end else begin
            // add a when the current bit of b is set
            acc_in  = sum_sub[VALUE_WIDTH] ? sum[VALUE_WIDTH-1:0] : sum_sub[VALUE_WIDTH-1:0];
            b_in    = {b_ff[VALUE_WIDTH-2:0], 1'b0};
            cnt_in  = cnt_ff - CW'(1);
            half_in = 1'b0;
            if (cnt_ff == CW'(1)) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      e_ff    <= e_in;
      y_ff    <= y_in;
      lhs_ff  <= lhs_in;
      acc_ff  <= acc_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      cnt_ff  <= cnt_in;
      half_ff <= half_in;
   end

   always_comb begin
      status.busy      = busy_ff;
      status.done      = done_ff;
      status.equal     = (lhs_ff == acc_ff);
      status.challenge = e_ff;
   end

endmodule

[rtl/core/zkid_ctrl.sv]
// Controller: session phase, round count, multiply pass sequencing and the result register.
// Depends on zkid_pkg; commands zkid_dp through dp_cmd_type / dp_status_type.
module zkid_ctrl
   import zkid_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_operation,
   input  logic                   req_random_bit,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_challenge,
   output logic                   rsp_challenge_valid,
   output logic                   rsp_round_checked,
   output logic                   rsp_round_ok,
   output logic                   rsp_session_passed,
   output logic                   rsp_session_failed,
   input  logic [ROUND_WIDTH-1:0] round_count,
   output dp_cmd_type             cmd,
   input  dp_status_type          status
);

   typedef enum logic [2:0] {
      ST_READY,
      ST_RED_Y,
      ST_SQUARE,
      ST_RED_V,
      ST_MUL_X,
      ST_RED_X,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_COMMIT,
      PH_RESPONSE
   } phase_type;

   state_type              state_ff, state_in;
   phase_type              phase_ff, phase_in;
   logic [ROUND_WIDTH-1:0] rounds_ff, rounds_in, rounds_inc;
   logic                   start_ff, start_in;
   logic                   save_lhs_ff, save_lhs_in;
   a_sel_type              a_sel_ff, a_sel_in;
   b_sel_type              b_sel_ff, b_sel_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   chal_ff, chal_in;
   logic                   chal_valid_ff, chal_valid_in;
   logic                   checked_ff, checked_in;
   logic                   ok_ff, ok_in;
   logic                   passed_ff, passed_in;
   logic                   failed_ff, failed_in;
   logic                   accept, slot_free, cap_commit, cap_resp;

   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != ST_READY) || !slot_free;
   assign accept     = req_valid && !req_stall;
   assign rounds_inc = rounds_ff + ROUND_WIDTH'(1);

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      rounds_in     = rounds_ff;
      start_in      = 1'b0;
      save_lhs_in   = 1'b0;
      a_sel_in      = a_sel_ff;
      b_sel_in      = b_sel_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      chal_in       = chal_ff;
      chal_valid_in = chal_valid_ff;
      checked_in    = checked_ff;
      ok_in         = ok_ff;
      passed_in     = passed_ff;
      failed_in     = failed_ff;
      cap_commit    = 1'b0;
      cap_resp      = 1'b0;
      unique case (state_ff)
         ST_READY: begin
            if (accept) begin
               rsp_valid_in  = 1'b1;
               chal_in       = 1'b0;
               chal_valid_in = 1'b0;
               checked_in    = 1'b0;
               ok_in         = 1'b0;
               passed_in     = 1'b0;
               failed_in     = 1'b0;
               unique case (req_operation)
                  OP_START: begin
                     rounds_in = '0;
                     phase_in  = PH_COMMIT;
                  end
                  OP_COMMIT: begin
                     if (phase_ff == PH_COMMIT) begin
                        cap_commit    = 1'b1;
                        phase_in      = PH_RESPONSE;
                        chal_in       = req_random_bit;
                        chal_valid_in = 1'b1;
                     end else begin
                        phase_in  = PH_IDLE;
                        failed_in = 1'b1;
                     end
                  end
                  OP_RESPONSE: begin
                     if (phase_ff == PH_RESPONSE) begin
                        // hold the result back until the check completes
                        cap_resp     = 1'b1;
                        rsp_valid_in = 1'b0;
                        state_in     = ST_RED_Y;
                        start_in     = 1'b1;
                        a_sel_in     = ASEL_ONE;
                        b_sel_in     = BSEL_Y;
                     end else begin
                        phase_in  = PH_IDLE;
                        failed_in = 1'b1;
                     end
                  end
                  OP_RESERVED: begin
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RED_Y: begin
            if (status.done) begin
               state_in = ST_SQUARE;
               start_in = 1'b1;
               a_sel_in = ASEL_ACC;
               b_sel_in = BSEL_Y;
            end
         end
         ST_SQUARE: begin
            if (status.done) begin
               save_lhs_in = 1'b1;
               start_in    = 1'b1;
               a_sel_in    = ASEL_ONE;
               if (status.challenge) begin
                  state_in = ST_RED_V;
                  b_sel_in = BSEL_V;
               end else begin
                  state_in = ST_RED_X;
                  b_sel_in = BSEL_X;
               end
            end
         end
         ST_RED_V: begin
            if (status.done) begin
               state_in = ST_MUL_X;
               start_in = 1'b1;
               a_sel_in = ASEL_ACC;
               b_sel_in = BSEL_X;
            end
         end
         ST_MUL_X, ST_RED_X: begin
            if (status.done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               state_in      = ST_READY;
               rsp_valid_in  = 1'b1;
               chal_in       = 1'b0;
               chal_valid_in = 1'b0;
               checked_in    = 1'b1;
               ok_in         = status.equal;
               passed_in     = 1'b0;
               failed_in     = !status.equal;
               if (status.equal) begin
                  rounds_in = rounds_inc;
                  if (rounds_inc >= round_count) begin
                     passed_in = 1'b1;
                     phase_in  = PH_IDLE;
                  end else begin
                     phase_in = PH_COMMIT;
                  end
               end else begin
                  phase_in = PH_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_READY;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_READY;
         phase_ff      <= PH_IDLE;
         rounds_ff     <= '0;
         start_ff      <= 1'b0;
         save_lhs_ff   <= 1'b0;
         a_sel_ff      <= ASEL_ONE;
         b_sel_ff      <= BSEL_Y;
         rsp_valid_ff  <= 1'b0;
         chal_ff       <= 1'b0;
         chal_valid_ff <= 1'b0;
         checked_ff    <= 1'b0;
         ok_ff         <= 1'b0;
         passed_ff     <= 1'b0;
         failed_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         rounds_ff     <= rounds_in;
         start_ff      <= start_in;
         save_lhs_ff   <= save_lhs_in;
         a_sel_ff      <= a_sel_in;
         b_sel_ff      <= b_sel_in;
         rsp_valid_ff  <= rsp_valid_in;
         chal_ff       <= chal_in;
         chal_valid_ff <= chal_valid_in;
         checked_ff    <= checked_in;
         ok_ff         <= ok_in;
         passed_ff     <= passed_in;
         failed_ff     <= failed_in;
      end
   end

   always_comb begin
      cmd.capture_commit = cap_commit;
      cmd.capture_resp   = cap_resp;
      cmd.start          = start_ff;
      cmd.save_lhs       = save_lhs_ff;
      cmd.a_sel          = a_sel_ff;
      cmd.b_sel          = b_sel_ff;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_challenge       = chal_ff;
   assign rsp_challenge_valid = chal_valid_ff;
   assign rsp_round_checked   = checked_ff;
   assign rsp_round_ok        = ok_ff;
   assign rsp_session_passed  = passed_ff;
   assign rsp_session_failed  = failed_ff;

`ifndef ASSERT_OFF
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !status.busy)
      else $error("multiply pass started while the datapath is busy");

   a_done_waiting: assert property (@(posedge clock) disable iff (reset)
      status.done |-> (state_ff == ST_RED_Y || state_ff == ST_SQUARE ||
                       state_ff == ST_RED_V || state_ff == ST_MUL_X ||
                       state_ff == ST_RED_X))
      else $error("datapath finished a pass nobody waits for");

   a_pass_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && passed_ff |-> ok_ff && checked_ff && !failed_ff)
      else $error("session passed without a verified round");

   a_chal_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && chal_valid_ff |-> !checked_ff && !failed_ff)
      else $error("challenge result also carries a check outcome");
`endif

endmodule

[dv/zero_knowledge_id_verifier_test.sv]
// Self-checking bench for the identification verifier: directed protocol corners, then
// random sessions with noise and back-pressure. Depends on zkid_pkg and the block's RTL.
`timescale 1ns / 100ps

module zero_knowledge_id_verifier_test;
   import zkid_pkg::*;

   localparam int VALUE_W = 40;

   // there is no register behind this index: a write to it must be ignored
   localparam logic [1:0] CSR_UNMAPPED = 2'd3;

   // one result as seen on rsp_, first member in the top bit
   typedef struct packed {
      logic challenge;
      logic challenge_valid;
      logic round_checked;
      logic round_ok;
      logic session_passed;
      logic session_failed;
   } verdict_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_AWAIT_COMMIT,
      PH_AWAIT_RESPONSE
   } session_phase_type;

   // ---------------------------------------------------------------------------------
   // Block ports; every input holds a known value from time zero
   // ---------------------------------------------------------------------------------
   logic               clock          = 1'b0;
   logic               reset          = 1'b1;
   logic               req_valid      = 1'b0;
   logic               req_stall;
   logic [1:0]         req_operation  = OP_START;
   logic [VALUE_W-1:0] req_value      = '0;
   logic               req_random_bit = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall      = 1'b0;
   logic               rsp_challenge;
   logic               rsp_challenge_valid;
   logic               rsp_round_checked;
   logic               rsp_round_ok;
   logic               rsp_session_passed;
   logic               rsp_session_failed;
   logic               csr_valid      = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index      = CSR_MODULUS;
   logic [VALUE_W-1:0] csr_data       = '0;

   zero_knowledge_id_verifier #(
      .VALUE_WIDTH(VALUE_W)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_value          (req_value),
      .req_random_bit     (req_random_bit),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_challenge      (rsp_challenge),
      .rsp_challenge_valid(rsp_challenge_valid),
      .rsp_round_checked  (rsp_round_checked),
      .rsp_round_ok       (rsp_round_ok),
      .rsp_session_passed (rsp_session_passed),
      .rsp_session_failed (rsp_session_failed),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   // ---------------------------------------------------------------------------------
   // Shared bench state
   // ---------------------------------------------------------------------------------
   verdict_type pending_verdicts[$];   // expected results, oldest first
   int          error_count     = 0;
   int          requests_sent   = 0;   // accepted requests, reserved ones left out
   int          send_idle_pct   = 0;
   int          recv_stall_pct  = 0;
   int          stall_hold_left = 0;   // cycles of forced receiver hold-off still to run

   // mirror of the block's registers and session state
   logic [VALUE_W-1:0]     cfg_modulus;
   logic [VALUE_W-1:0]     cfg_public;
   logic [ROUND_WIDTH-1:0] cfg_rounds;
   logic [VALUE_W-1:0]     held_commitment;
   logic                   held_challenge;
   logic [ROUND_WIDTH-1:0] rounds_passed;
   session_phase_type      session_phase;

   // square root of the public value, known to the simulated prover
   logic [VALUE_W-1:0]     key_secret;

   string field_name [6] = '{"session_failed", "session_passed", "round_ok",
                             "round_checked", "challenge_valid", "challenge"};

   // ---------------------------------------------------------------------------------
   // Modular arithmetic, done exactly on double-width products
   // ---------------------------------------------------------------------------------
   function automatic logic [VALUE_W-1:0] effective_modulus();
      return (cfg_modulus < 2) ? VALUE_W'(2) : cfg_modulus;
   endfunction

   function automatic logic [VALUE_W-1:0] mod_product(logic [VALUE_W-1:0] a,
                                                       logic [VALUE_W-1:0] b,
                                                       logic [VALUE_W-1:0] m);
      logic [2*VALUE_W-1:0] wide;
      wide = {{VALUE_W{1'b0}}, a} * {{VALUE_W{1'b0}}, b};
      return VALUE_W'(wide % {{VALUE_W{1'b0}}, m});
   endfunction

   function automatic logic [VALUE_W-1:0] rand_value();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[VALUE_W-1:0];
   endfunction

   function automatic logic [VALUE_W-1:0] rand_below(logic [VALUE_W-1:0] m);
      logic [95:0] r;
      r = {$urandom, $urandom, $urandom};
      return VALUE_W'(r % {{(96-VALUE_W){1'b0}}, m});
   endfunction

   // now and then add one modulus so the block has to reduce the operand itself
   function automatic logic [VALUE_W-1:0] maybe_unreduced(logic [VALUE_W-1:0] v,
                                                           logic [VALUE_W-1:0] m);
      logic [VALUE_W:0] sum;
      sum = {1'b0, v} + {1'b0, m};
      if (!sum[VALUE_W] && $urandom_range(3) == 0)
         return sum[VALUE_W-1:0];
      return v;
   endfunction

   // ---------------------------------------------------------------------------------
   // Predictor: advance the mirrored session by one request and give its verdict
   // ---------------------------------------------------------------------------------
   function automatic verdict_type judge_request(logic [1:0] op, logic [VALUE_W-1:0] val,
                                                 logic coin);
      verdict_type        v;
      logic [VALUE_W-1:0] n;
      logic [VALUE_W-1:0] factor;
      v = '0;
      n = effective_modulus();
      case (op)
         OP_START: begin
            rounds_passed = '0;
            session_phase = PH_AWAIT_COMMIT;
         end
         OP_COMMIT: begin
            if (session_phase == PH_AWAIT_COMMIT) begin
               held_commitment   = val;
               held_challenge    = coin;
               session_phase     = PH_AWAIT_RESPONSE;
               v.challenge       = coin;
               v.challenge_valid = 1'b1;
            end else begin
               session_phase    = PH_IDLE;
               v.session_failed = 1'b1;
            end
         end
         OP_RESPONSE: begin
            if (session_phase == PH_AWAIT_RESPONSE) begin
               factor          = held_challenge ? VALUE_W'(cfg_public % n) : VALUE_W'(1);
               v.round_checked = 1'b1;
               if (mod_product(val, val, n) == mod_product(held_commitment, factor, n)) begin
                  v.round_ok    = 1'b1;
                  rounds_passed = rounds_passed + 1'b1;
                  if (rounds_passed >= cfg_rounds) begin
                     v.session_passed = 1'b1;
                     session_phase    = PH_IDLE;
                  end else begin
                     session_phase = PH_AWAIT_COMMIT;
                  end
               end else begin
                  v.session_failed = 1'b1;
                  session_phase    = PH_IDLE;
               end
            end else begin
               session_phase    = PH_IDLE;
               v.session_failed = 1'b1;
            end
         end
         default: ;   // reserved operation: nothing moves
      endcase
      return v;
   endfunction

   // ---------------------------------------------------------------------------------
   // Clock, time limit and receiver
   // ---------------------------------------------------------------------------------
   initial begin
      forever #5 clock = ~clock;
   end

   // generous ceiling: several times the slowest correct run
   initial begin
      #30_000_000;
      $display("** zero_knowledge_id_verifier: FAILED **");
      $finish;
   end

   // Drive stall at the falling edge: honour a forced hold-off first, else stall at random.
   always @(negedge clock) begin
      if (stall_hold_left > 0) begin
         stall_hold_left = stall_hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Check every accepted result against the oldest verdict still waiting.
   always @(posedge clock) begin
      verdict_type seen;
      verdict_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = {rsp_challenge, rsp_challenge_valid, rsp_round_checked,
                 rsp_round_ok, rsp_session_passed, rsp_session_failed};
         if (pending_verdicts.size() == 0) begin
            error_count++;
            $display("%0t: result %b arrived with nothing expected", $time, seen);
         end else begin
            want = pending_verdicts.pop_front();
            for (int i = 0; i < 6; i++) begin
               if (want[i] !== seen[i]) begin
                  error_count++;
                  $display("%0t: %s expected %b, got %b", $time, field_name[i],
                           want[i], seen[i]);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Sender side; every task starts and ends at a falling edge
   // ---------------------------------------------------------------------------------

   // Offer one request, hold it until taken, then record its verdict.
   task automatic send_request(input logic [1:0] op, input logic [VALUE_W-1:0] val,
                               input logic coin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_value      <= val;
      req_random_bit <= coin;
      do @(posedge clock); while (req_stall);
      pending_verdicts.push_back(judge_request(op, val, coin));
      if (op != OP_RESERVED)
         requests_sent++;
      @(negedge clock);
   endtask

   // Drop valid and hold off until every verdict has been matched, plus some settling.
   task automatic await_quiet(input int settle_cycles);
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0)
         @(negedge clock);
      repeat (settle_cycles) @(negedge clock);
   endtask

   // Write one register, only ever with the block idle.
   task automatic write_register(input logic [1:0] idx, input logic [VALUE_W-1:0] data);
      await_quiet(2);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_MODULUS:      cfg_modulus = data;
         CSR_PUBLIC_VALUE: cfg_public  = data;
         CSR_ROUND_COUNT:  cfg_rounds  = data[ROUND_WIDTH-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Pick a modulus and a public value; mostly v = s^2 so an honest prover can pass.
   task automatic load_random_key(input int rootless_pct);
      logic [VALUE_W-1:0] m;
      logic [VALUE_W-1:0] n;
      logic [VALUE_W-1:0] v;
      case ($urandom_range(9))
         0:       m = VALUE_W'($urandom_range(3));
         1:       m = '1;
         2:       m = VALUE_W'($urandom_range(1023, 2));
         default: m = rand_value() | ({VALUE_W{1'($urandom_range(1))}} &
                                      (VALUE_W'(1) << (VALUE_W - 1)));
      endcase
      write_register(CSR_MODULUS, m);
      n          = effective_modulus();
      key_secret = rand_below(n);
      v          = maybe_unreduced(mod_product(key_secret, key_secret, n), n);
      if ($urandom_range(99) < rootless_pct)
         v = rand_value();
      write_register(CSR_PUBLIC_VALUE, v);
      if ($urandom_range(9) == 0)
         write_register(CSR_UNMAPPED, rand_value());
   endtask

   // Round count in the low byte, junk above it.
   task automatic load_round_count(input logic [ROUND_WIDTH-1:0] rounds);
      logic [VALUE_W-1:0] data;
      data = rand_value();
      data[ROUND_WIDTH-1:0] = rounds;
      write_register(CSR_ROUND_COUNT, data);
   endtask

   // Run one session as an honest prover, with optional wrong answers and disorder.
   task automatic run_session(input int max_rounds, input int bad_pct, input int noise_pct);
      logic [VALUE_W-1:0] n;
      logic [VALUE_W-1:0] nonce;
      logic [VALUE_W-1:0] answer;
      logic               coin;
      n = effective_modulus();
      send_request(OP_START, rand_value(), $urandom_range(1));
      for (int r = 0; r < max_rounds; r++) begin
         if ($urandom_range(99) < noise_pct) begin
            case ($urandom_range(2))
               0: send_request(OP_RESERVED, rand_value(), $urandom_range(1));
               1: send_request(OP_START, rand_value(), $urandom_range(1));
               default: begin
                  // response before its commitment: aborts the session
                  send_request(OP_RESPONSE, rand_value(), $urandom_range(1));
                  break;
               end
            endcase
         end
         coin  = $urandom_range(1);
         nonce = rand_below(n);
         send_request(OP_COMMIT, maybe_unreduced(mod_product(nonce, nonce, n), n), coin);
         if ($urandom_range(99) < noise_pct) begin
            send_request(OP_COMMIT, rand_value(), $urandom_range(1));
            break;
         end
         answer = coin ? mod_product(nonce, key_secret, n) : nonce;
         answer = maybe_unreduced(answer, n);
         if ($urandom_range(99) < bad_pct)
            answer = rand_value();
         send_request(OP_RESPONSE, answer, $urandom_range(1));
         if (session_phase != PH_AWAIT_COMMIT)
            break;
      end
   endtask

   // ---------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------

   // Requests outside a session, the reserved code, and a wrong answer at reset settings.
   task automatic test_out_of_order_requests();
      send_request(OP_RESPONSE, '1, 1'b1);
      send_request(OP_COMMIT, '1, 1'b1);
      send_request(OP_RESERVED, '1, 1'b1);
      send_request(OP_START, '1, 1'b1);
      send_request(OP_COMMIT, '1, 1'b1);
      send_request(OP_RESPONSE, '1, 1'b0);
   endtask

   // Moduli zero and one act as two; a round count of zero passes on the first round.
   task automatic test_degenerate_modulus();
      write_register(CSR_MODULUS, '0);
      write_register(CSR_PUBLIC_VALUE, VALUE_W'(1));
      load_round_count('0);
      send_request(OP_START, '0, 1'b0);
      send_request(OP_COMMIT, VALUE_W'(3), 1'b1);
      send_request(OP_RESPONSE, VALUE_W'(1), 1'b1);
      send_request(OP_COMMIT, '0, 1'b0);   // session already closed
      write_register(CSR_MODULUS, VALUE_W'(1));
      send_request(OP_START, '0, 1'b0);
      send_request(OP_COMMIT, '0, 1'b0);
      send_request(OP_RESPONSE, VALUE_W'(2), 1'b0);
   endtask

   // Largest modulus with every operand at or above it.
   task automatic test_extreme_operands();
      write_register(CSR_MODULUS, '1);
      write_register(CSR_PUBLIC_VALUE, '1);
      load_round_count(ROUND_WIDTH'(1));
      send_request(OP_START, '1, 1'b1);
      send_request(OP_COMMIT, '1, 1'b1);
      send_request(OP_RESPONSE, '1, 1'b1);
   endtask

   // A start reopens a session anywhere; a reserved request mid-round changes nothing.
   task automatic test_restart_and_reserved();
      send_request(OP_START, '0, 1'b0);
      send_request(OP_START, '1, 1'b1);
      send_request(OP_COMMIT, VALUE_W'(9), 1'b1);
      send_request(OP_COMMIT, VALUE_W'(9), 1'b0);
      send_request(OP_START, '0, 1'b0);
      send_request(OP_COMMIT, VALUE_W'(4), 1'b0);
      send_request(OP_RESERVED, VALUE_W'(4), 1'b1);
      send_request(OP_RESPONSE, VALUE_W'(2), 1'b0);
   endtask

   // Random sessions and noise under one idling mix, reconfiguring between sessions.
   task automatic test_random_sessions(input int sender_idle, input int receiver_idle,
                                       input int budget);
      int first_request;
      int rounds;
      send_idle_pct  = sender_idle;
      recv_stall_pct = receiver_idle;
      first_request  = requests_sent;
      load_random_key(5);
      load_round_count(ROUND_WIDTH'($urandom_range(6, 1)));
      while (requests_sent - first_request < budget) begin
         if ($urandom_range(4) == 0) begin
            load_random_key(5);
            case ($urandom_range(9))
               0:       load_round_count('0);
               1:       load_round_count(ROUND_WIDTH'($urandom_range(255, 9)));
               default: load_round_count(ROUND_WIDTH'($urandom_range(6, 1)));
            endcase
         end
         if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(3, 1))
               send_request(2'($urandom_range(3)), rand_value(), $urandom_range(1));
         end else begin
            if (cfg_rounds == 0)
               rounds = 1;
            else if (cfg_rounds > 8)
               rounds = $urandom_range(8, 1);
            else
               rounds = cfg_rounds;
            run_session(rounds, 10, 4);
         end
      end
   endtask

   // The full 255 rounds, all honest, back to back.
   task automatic test_longest_session();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      load_random_key(0);
      load_round_count('1);
      run_session(255, 0, 0);
   endtask

   // Hold the receiver off for a long stretch while requests keep coming, then drain.
   task automatic test_receiver_hold_off();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      load_random_key(0);
      load_round_count(ROUND_WIDTH'(3));
      @(posedge clock);
      stall_hold_left = 400;
      @(negedge clock);
      run_session(3, 0, 0);
      await_quiet(2);
   endtask

   // ---------------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------------
   initial begin
      // initialise the mirror to the block's reset values
      cfg_modulus     = VALUE_W'(2);
      cfg_public      = '0;
      cfg_rounds      = ROUND_WIDTH'(20);
      held_commitment = '0;
      held_challenge  = 1'b0;
      rounds_passed   = '0;
      session_phase   = PH_IDLE;
      key_secret      = '0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct  = 15;
      recv_stall_pct = 72;
      test_out_of_order_requests();
      test_degenerate_modulus();
      test_extreme_operands();
      test_restart_and_reserved();

      test_random_sessions(15, 72, 300);
      test_random_sessions(72, 15, 300);
      test_random_sessions(0, 0, 300);
      test_longest_session();
      test_receiver_hold_off();

      // let any stray result show itself after the last expected one
      await_quiet(400);
      if (error_count == 0) begin
         $display("** zero_knowledge_id_verifier: PASSED **");
      end else begin
         $display("** zero_knowledge_id_verifier: FAILED **");
      end
      $finish;
   end

endmodule
